// ===== hdl/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue package
// Sizes, operation and status codes, and the read-stage record used by the
// queue top level; the testbench uses the sizes and codes as well.
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

   // Ring size and the widths that follow from it.
   localparam int DEPTH   = 16;
   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int SUM_W   = IDX_W + 1;

   // Entry layout: age in the upper bits, grade bits in the lower bits.
   localparam int AGE_W   = 8;
   localparam int GRADE_W = 32;
   localparam int ENTRY_W = AGE_W + GRADE_W;

   // Operation codes.
   localparam int OP_W = 2;
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd0;
   localparam logic [OP_W-1:0] OP_PUSH_REAR  = 2'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd2;
   localparam logic [OP_W-1:0] OP_POP_REAR   = 2'd3;

   // Status codes.
   localparam int ST_W = 2;
   localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
   localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

   // What travels alongside the memory read while it is in flight.
   typedef struct packed {
      logic             pop_ok;
      logic [ST_W-1:0]  status;
      logic [CNT_W-1:0] occupancy;
   } s1_info_type;

endpackage

`default_nettype wire

// ===== hdl/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue
// A ring of slots in a synchronous RAM with a front index and a fill count.
// Each request beat pushes or pops at either end and returns one response.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Payload
//   req      in         req_valid/req_stall  op, entry_age, entry_grade_bits
//   rsp      out        rsp_valid/rsp_stall  out_age, out_grade_bits, status,
//                                            occupancy
//
// A request beat is accepted while req_stall is low; its response passes through
// the registered read port of the slot RAM and the read stage, then the response
// register. A new request may be accepted every cycle while the response
// side keeps draining. Reset empties the queue at once; slot contents are
// not cleared. When the response register is stalled and a beat is waiting
// in the read stage behind it, req_stall is raised until the response side
// moves.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire  [dq_pkg::OP_W-1:0]           req_op,
   input  wire  [dq_pkg::AGE_W-1:0]          req_entry_age,
   input  wire  [dq_pkg::GRADE_W-1:0]        req_entry_grade_bits,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic [dq_pkg::AGE_W-1:0]          rsp_out_age,
   output logic [dq_pkg::GRADE_W-1:0]        rsp_out_grade_bits,
   output logic [dq_pkg::ST_W-1:0]           rsp_status,
   output logic [dq_pkg::CNT_W-1:0]          rsp_occupancy
);

   // Queue state.
   logic [dq_pkg::IDX_W-1:0]   front_ff, front_in;
   logic [dq_pkg::CNT_W-1:0]   count_ff, count_in;

   // Read stage and response register.
   logic                        s1_valid_ff, s1_valid_in;
   dq_pkg::s1_info_type         s1_info_ff, s1_info_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [dq_pkg::AGE_W-1:0]    rsp_age_ff, rsp_age_in;
   logic [dq_pkg::GRADE_W-1:0]  rsp_grade_ff, rsp_grade_in;
   logic [dq_pkg::ST_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [dq_pkg::CNT_W-1:0]    rsp_occ_ff, rsp_occ_in;

   logic                        accept;
   logic                        s1_move;
   logic                        is_push;
   logic                        q_full;
   logic                        q_empty;
   logic                        push_ok;
   logic                        pop_ok;
   logic [dq_pkg::IDX_W-1:0]    front_dec;
   logic [dq_pkg::IDX_W-1:0]    front_inc;
   logic [dq_pkg::SUM_W-1:0]    sum_push;
   logic [dq_pkg::SUM_W-1:0]    sum_pop;
   logic [dq_pkg::IDX_W-1:0]    rear_push_pos;
   logic [dq_pkg::IDX_W-1:0]    rear_pop_pos;

   logic                        ram_wr_en;
   logic [dq_pkg::IDX_W-1:0]    ram_wr_addr;
   logic                        ram_rd_en;
   logic [dq_pkg::IDX_W-1:0]    ram_rd_addr;
   logic [dq_pkg::ENTRY_W-1:0]  ram_rd_data;

   // Handshake: the read stage moves on whenever the response register is free.
   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_move;
   assign accept    = req_valid && !req_stall;

   // Operation decode against the current fill level.
   assign is_push = (req_op == dq_pkg::OP_PUSH_FRONT) || (req_op == dq_pkg::OP_PUSH_REAR);
   assign q_full  = (count_ff == dq_pkg::CNT_W'(dq_pkg::DEPTH));
   assign q_empty = (count_ff == '0);
   assign push_ok = is_push && !q_full;
   assign pop_ok  = !is_push && !q_empty;

   // Ring positions, wrapped modulo the depth.
   always_comb begin
      front_dec = (front_ff == '0) ? dq_pkg::IDX_W'(dq_pkg::DEPTH - 1) : front_ff - 1'b1;
      front_inc = (front_ff == dq_pkg::IDX_W'(dq_pkg::DEPTH - 1)) ? '0 : front_ff + 1'b1;
      sum_push  = dq_pkg::SUM_W'(front_ff) + dq_pkg::SUM_W'(count_ff);
      sum_pop   = sum_push - 1'b1;
      rear_push_pos = (sum_push >= dq_pkg::SUM_W'(dq_pkg::DEPTH))
                    ? dq_pkg::IDX_W'(sum_push - dq_pkg::SUM_W'(dq_pkg::DEPTH))
                    : dq_pkg::IDX_W'(sum_push);
      rear_pop_pos  = (sum_pop >= dq_pkg::SUM_W'(dq_pkg::DEPTH))
                    ? dq_pkg::IDX_W'(sum_pop - dq_pkg::SUM_W'(dq_pkg::DEPTH))
                    : dq_pkg::IDX_W'(sum_pop);
   end

   // Memory accesses are issued on the accepting edge.
   assign ram_wr_en   = accept && push_ok;
   assign ram_wr_addr = (req_op == dq_pkg::OP_PUSH_FRONT) ? front_dec : rear_push_pos;
   assign ram_rd_en   = accept && pop_ok;
   assign ram_rd_addr = (req_op == dq_pkg::OP_POP_FRONT) ? front_ff : rear_pop_pos;

   dq_ram #(
      .WIDTH (dq_pkg::ENTRY_W),
      .DEPTH (dq_pkg::DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data ({req_entry_age, req_entry_grade_bits}),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Next front index and fill count.
   always_comb begin
      front_in = front_ff;
      count_in = count_ff;
      if (accept) begin
         case (req_op)
            dq_pkg::OP_PUSH_FRONT: begin
               if (push_ok) begin
                  front_in = front_dec;
                  count_in = count_ff + 1'b1;
               end
            end
            dq_pkg::OP_PUSH_REAR: begin
               if (push_ok) begin
                  count_in = count_ff + 1'b1;
               end
            end
            dq_pkg::OP_POP_FRONT: begin
               if (pop_ok) begin
                  front_in = front_inc;
                  count_in = count_ff - 1'b1;
               end
            end
            dq_pkg::OP_POP_REAR: begin
               if (pop_ok) begin
                  count_in = count_ff - 1'b1;
               end
            end
            default: begin
               front_in = front_ff;
               count_in = count_ff;
            end
         endcase
      end
   end

   // Read stage: status and occupancy wait here for the RAM data.
   always_comb begin
      s1_info_in.pop_ok    = pop_ok;
      s1_info_in.occupancy = count_in;
      if (is_push) begin
         s1_info_in.status = q_full ? dq_pkg::ST_FULL : dq_pkg::ST_DONE;
      end else begin
         s1_info_in.status = q_empty ? dq_pkg::ST_EMPTY : dq_pkg::ST_DONE;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   // Response register: popped entry or zeros, with status and occupancy.
   always_comb begin
      rsp_age_in    = rsp_age_ff;
      rsp_grade_in  = rsp_grade_ff;
      rsp_status_in = rsp_status_ff;
      rsp_occ_in    = rsp_occ_ff;
      if (s1_move) begin
         rsp_valid_in  = 1'b1;
         rsp_age_in    = s1_info_ff.pop_ok ? ram_rd_data[dq_pkg::ENTRY_W-1:dq_pkg::GRADE_W] : '0;
         rsp_grade_in  = s1_info_ff.pop_ok ? ram_rd_data[dq_pkg::GRADE_W-1:0] : '0;
         rsp_status_in = s1_info_ff.status;
         rsp_occ_in    = s1_info_ff.occupancy;
      end else begin
         rsp_valid_in  = rsp_valid_ff && rsp_stall;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff     <= front_in;
         count_ff     <= count_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_info_ff <= s1_info_in;
      end
      rsp_age_ff    <= rsp_age_in;
      rsp_grade_ff  <= rsp_grade_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_age        = rsp_age_ff;
   assign rsp_out_grade_bits = rsp_grade_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_occupancy      = rsp_occ_ff;

   // Checks on the queue state and the read stage.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= dq_pkg::CNT_W'(dq_pkg::DEPTH))
      else $error("Fill count exceeds the ring depth.");

   a_full_push_holds: assert property (@(posedge clock) disable iff (reset)
      (accept && is_push && q_full) |=> ($stable(count_ff) && $stable(front_ff)))
      else $error("A refused push changed the queue state.");

   a_pop_decrements: assert property (@(posedge clock) disable iff (reset)
      (accept && pop_ok) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("An accepted pop did not lower the fill count by one.");

   a_s1_held: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && rsp_stall) |=> (s1_valid_ff && $stable(s1_info_ff)))
      else $error("The read stage was lost while the response side was stalled.");

endmodule

`default_nettype wire

// ===== hdl/dq_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered and holds
// its value until the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire                                    clock,
   input  wire                                    wr_en,
   input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire  [WIDTH-1:0]                       wr_data,
   input  wire                                    rd_en,
   input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== tb/sv/double_ended_queue_tb.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Drives push and pop beats at both ends of the queue and checks every response
// against the directed table or a behavioural copy of the ring kept inside the
// bench. A short table of hand-picked beats covers the empty and full cases and
// the field extremes. Phases of random beats then follow, some heavy on pushes
// and some on pops. The request side sends in bursts and the response side
// stalls on its own pattern, with one long hold-off that backs the queue up.
// ----------------------------------------------------------------------------

module double_ended_queue_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DIR_N        = 25;
   localparam int RANDOM_BEATS = 550;
   localparam int HOLD_CYCLES  = 80;
   localparam int DRAIN_CYCLES = 10;
   localparam int IDLE_LIMIT   = 1000;

   // One response beat as the queue should produce it.
   typedef struct packed {
      logic [dq_pkg::AGE_W-1:0]   age;
      logic [dq_pkg::GRADE_W-1:0] grade;
      logic [dq_pkg::ST_W-1:0]    status;
      logic [dq_pkg::CNT_W-1:0]   occupancy;
   } dq_resp_type;

   // One row of the directed table; the expected response is only used when
   // the row is marked as hand-checked.
   typedef struct packed {
      logic [dq_pkg::OP_W-1:0]    op;
      logic [dq_pkg::AGE_W-1:0]   age;
      logic [dq_pkg::GRADE_W-1:0] grade;
      logic                       hand_checked;
      dq_resp_type                resp;
   } dq_row_type;

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic [dq_pkg::OP_W-1:0]      req_op;
   logic [dq_pkg::AGE_W-1:0]     req_entry_age;
   logic [dq_pkg::GRADE_W-1:0]   req_entry_grade_bits;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic [dq_pkg::AGE_W-1:0]     rsp_out_age;
   logic [dq_pkg::GRADE_W-1:0]   rsp_out_grade_bits;
   logic [dq_pkg::ST_W-1:0]      rsp_status;
   logic [dq_pkg::CNT_W-1:0]     rsp_occupancy;

   // Shadow copy of the ring.
   logic [dq_pkg::ENTRY_W-1:0]   ring_slots [dq_pkg::DEPTH];
   int                           ring_front = 0;
   int                           ring_count = 0;

   dq_resp_type                  awaited_responses [$];
   int                           error_count = 0;
   int                           burst_left = 0;
   int                           idle_cycles = 0;
   bit                           hold_off_pending = 1'b0;

   // Directed beats: empty pops, extremes, a fill to full and refused pushes.
   dq_row_type directed_rows [DIR_N] = '{
      '{dq_pkg::OP_POP_FRONT,  8'h00, 32'h0000_0000, 1'b1,
        '{8'h00, 32'h0, dq_pkg::ST_EMPTY, 5'd0}},
      '{dq_pkg::OP_POP_REAR,   8'hFF, 32'hFFFF_FFFF, 1'b1,
        '{8'h00, 32'h0, dq_pkg::ST_EMPTY, 5'd0}},
      '{dq_pkg::OP_PUSH_FRONT, 8'hFF, 32'hFFFF_FFFF, 1'b1,
        '{8'h00, 32'h0, dq_pkg::ST_DONE, 5'd1}},
      '{dq_pkg::OP_PUSH_REAR,  8'h00, 32'h0000_0000, 1'b1,
        '{8'h00, 32'h0, dq_pkg::ST_DONE, 5'd2}},
      '{dq_pkg::OP_POP_FRONT,  8'h00, 32'h0000_0000, 1'b1,
        '{8'hFF, 32'hFFFF_FFFF, dq_pkg::ST_DONE, 5'd1}},
      '{dq_pkg::OP_POP_REAR,   8'hFF, 32'hFFFF_FFFF, 1'b1,
        '{8'h00, 32'h0, dq_pkg::ST_DONE, 5'd0}},
      '{dq_pkg::OP_PUSH_REAR,  8'h01, 32'h0000_0001, 1'b0, '0},
      '{dq_pkg::OP_PUSH_FRONT, 8'h80, 32'h8000_0000, 1'b0, '0},
      '{dq_pkg::OP_PUSH_REAR,  8'hA5, 32'hA5A5_A5A5, 1'b0, '0},
      '{dq_pkg::OP_PUSH_FRONT, 8'h5A, 32'h5A5A_5A5A, 1'b0, '0},
      '{dq_pkg::OP_PUSH_REAR,  8'h0F, 32'h0F0F_0F0F, 1'b0, '0},
      '{dq_pkg::OP_PUSH_FRONT, 8'hF0, 32'hF0F0_F0F0, 1'b0, '0},
      '{dq_pkg::OP_PUSH_REAR,  8'h33, 32'h3333_3333, 1'b0, '0},
      '{dq_pkg::OP_PUSH_FRONT, 8'hCC, 32'hCCCC_CCCC, 1'b0, '0},
      '{dq_pkg::OP_PUSH_REAR,  8'h7F, 32'h7FFF_FFFF, 1'b0, '0},
      '{dq_pkg::OP_PUSH_FRONT, 8'hFE, 32'hFFFF_FFFE, 1'b0, '0},
      '{dq_pkg::OP_PUSH_REAR,  8'h12, 32'h1234_5678, 1'b0, '0},
      '{dq_pkg::OP_PUSH_FRONT, 8'h9A, 32'h9ABC_DEF0, 1'b0, '0},
      '{dq_pkg::OP_PUSH_REAR,  8'h00, 32'h0000_0000, 1'b0, '0},
      '{dq_pkg::OP_PUSH_FRONT, 8'hFF, 32'hFFFF_FFFF, 1'b0, '0},
      '{dq_pkg::OP_PUSH_REAR,  8'h55, 32'h5555_5555, 1'b0, '0},
      '{dq_pkg::OP_PUSH_FRONT, 8'hAA, 32'hAAAA_AAAA, 1'b0, '0},
      '{dq_pkg::OP_PUSH_REAR,  8'h11, 32'h1111_1111, 1'b1,
        '{8'h00, 32'h0, dq_pkg::ST_FULL, dq_pkg::CNT_W'(dq_pkg::DEPTH)}},
      '{dq_pkg::OP_PUSH_FRONT, 8'h22, 32'h2222_2222, 1'b1,
        '{8'h00, 32'h0, dq_pkg::ST_FULL, dq_pkg::CNT_W'(dq_pkg::DEPTH)}},
      '{dq_pkg::OP_POP_REAR,   8'h00, 32'h0000_0000, 1'b0, '0}
   };

   double_ended_queue dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_op               (req_op),
      .req_entry_age        (req_entry_age),
      .req_entry_grade_bits (req_entry_grade_bits),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_out_age          (rsp_out_age),
      .rsp_out_grade_bits   (rsp_out_grade_bits),
      .rsp_status           (rsp_status),
      .rsp_occupancy        (rsp_occupancy)
   );

   always #2 clock = ~clock;

   // Applies one operation to the shadow ring and returns its response.
   function automatic dq_resp_type apply_deque_op(input logic [dq_pkg::OP_W-1:0] op,
                                                  input logic [dq_pkg::AGE_W-1:0] age,
                                                  input logic [dq_pkg::GRADE_W-1:0] grade);
      dq_resp_type                resp;
      int                         pos;
      logic [dq_pkg::ENTRY_W-1:0] entry;
      resp = '0;
      resp.status = dq_pkg::ST_DONE;
      if (op == dq_pkg::OP_PUSH_FRONT || op == dq_pkg::OP_PUSH_REAR) begin
         if (ring_count >= dq_pkg::DEPTH) begin
            resp.status = dq_pkg::ST_FULL;
         end else if (op == dq_pkg::OP_PUSH_FRONT) begin
            ring_front = (ring_front + dq_pkg::DEPTH - 1) % dq_pkg::DEPTH;
            ring_slots[ring_front] = {age, grade};
            ring_count++;
         end else begin
            pos = (ring_front + ring_count) % dq_pkg::DEPTH;
            ring_slots[pos] = {age, grade};
            ring_count++;
         end
      end else begin
         if (ring_count == 0) begin
            resp.status = dq_pkg::ST_EMPTY;
         end else begin
            if (op == dq_pkg::OP_POP_FRONT) begin
               pos = ring_front;
               ring_front = (ring_front + 1) % dq_pkg::DEPTH;
            end else begin
               pos = (ring_front + ring_count - 1) % dq_pkg::DEPTH;
            end
            entry = ring_slots[pos];
            resp.age = entry[dq_pkg::ENTRY_W-1:dq_pkg::GRADE_W];
            resp.grade = entry[dq_pkg::GRADE_W-1:0];
            ring_count--;
         end
      end
      resp.occupancy = ring_count[dq_pkg::CNT_W-1:0];
      return resp;
   endfunction

   // Offers one request beat, opening a new burst after a short gap when the
   // current one is used up, and returns once the beat has been accepted.
   task automatic send_request(input logic [dq_pkg::OP_W-1:0] op,
                               input logic [dq_pkg::AGE_W-1:0] age,
                               input logic [dq_pkg::GRADE_W-1:0] grade);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         burst_left = $urandom_range(1, 30);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_op <= op;
      req_entry_age <= age;
      req_entry_grade_bits <= grade;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Compares one response beat with the oldest awaited response.
   task automatic check_response();
      dq_resp_type want;
      if (awaited_responses.size() == 0) begin
         $display("%0t: response beat with nothing awaited: age %h grade %h status %0d occ %0d",
                  $time, rsp_out_age, rsp_out_grade_bits, rsp_status, rsp_occupancy);
         error_count++;
      end else begin
         want = awaited_responses.pop_front();
         if (rsp_out_age !== want.age) begin
            $display("%0t: age mismatch: expected %h, got %h", $time, want.age, rsp_out_age);
            error_count++;
         end
         if (rsp_out_grade_bits !== want.grade) begin
            $display("%0t: grade mismatch: expected %h, got %h",
                     $time, want.grade, rsp_out_grade_bits);
            error_count++;
         end
         if (rsp_status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, got %0d",
                     $time, want.status, rsp_status);
            error_count++;
         end
         if (rsp_occupancy !== want.occupancy) begin
            $display("%0t: occupancy mismatch: expected %0d, got %0d",
                     $time, want.occupancy, rsp_occupancy);
            error_count++;
         end
      end
   endtask

   // Response monitor.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         check_response();
      end
   end

   // Watchdog on cycles in which neither channel moves a beat.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Response-side stall pattern: spans of random length, each with its own
   // stall density, and one long hold-off when the stimulus asks for it.
   initial begin
      int span;
      int density;
      rsp_stall = 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            repeat (HOLD_CYCLES) begin
               @(posedge clock);
               rsp_stall <= 1'b1;
            end
         end
         span = $urandom_range(10, 120);
         case ($urandom_range(0, 3))
            0: density = 0;
            1: density = 30;
            2: density = 60;
            default: density = 90;
         endcase
         repeat (span) begin
            @(posedge clock);
            rsp_stall <= ($urandom_range(0, 99) < density);
         end
      end
   end

   // Reset, directed table, random phases, then drain and report.
   initial begin
      int                         seg_left;
      int                         push_pct;
      logic [dq_pkg::OP_W-1:0]    op;
      logic [dq_pkg::AGE_W-1:0]   age;
      logic [dq_pkg::GRADE_W-1:0] grade;
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = dq_pkg::OP_PUSH_FRONT;
      req_entry_age = '0;
      req_entry_grade_bits = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part.
      for (int i = 0; i < DIR_N; i++) begin
         send_request(directed_rows[i].op, directed_rows[i].age, directed_rows[i].grade);
         if (directed_rows[i].hand_checked) begin
            void'(apply_deque_op(directed_rows[i].op, directed_rows[i].age,
                                 directed_rows[i].grade));
            awaited_responses.push_back(directed_rows[i].resp);
         end else begin
            awaited_responses.push_back(apply_deque_op(directed_rows[i].op,
                                                       directed_rows[i].age,
                                                       directed_rows[i].grade));
         end
      end

      // Random part in phases that lean towards pushes or pops, so that the
      // queue swings between empty and full and the indices wrap often.
      seg_left = 0;
      push_pct = 50;
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(20, 60);
            case ($urandom_range(0, 3))
               0: push_pct = 10;
               1: push_pct = 50;
               2: push_pct = 80;
               default: push_pct = 100;
            endcase
         end
         seg_left--;
         if (n == 150) begin
            hold_off_pending = 1'b1;
         end
         if ($urandom_range(0, 99) < push_pct) begin
            op = $urandom_range(0, 1) ? dq_pkg::OP_PUSH_REAR : dq_pkg::OP_PUSH_FRONT;
         end else begin
            op = $urandom_range(0, 1) ? dq_pkg::OP_POP_REAR : dq_pkg::OP_POP_FRONT;
         end
         case ($urandom_range(0, 7))
            0: begin
               age = '0;
               grade = '0;
            end
            1: begin
               age = '1;
               grade = '1;
            end
            default: begin
               age = dq_pkg::AGE_W'($urandom_range(0, 255));
               grade = $urandom;
            end
         endcase
         send_request(op, age, grade);
         awaited_responses.push_back(apply_deque_op(op, age, grade));
      end
      req_valid <= 1'b0;

      // Wait for every awaited response, then look for stray ones.
      while (awaited_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== double_ended_queue.f =====
hdl/dq_pkg.sv
hdl/dq_ram.sv
hdl/double_ended_queue.sv
tb/sv/double_ended_queue_tb.sv
